// ===== rtl/rpalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpalloc_pkg: shared definitions for the ref-counted page allocator
// Field widths, function and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rpalloc_pkg;

    // Field widths of the request and response channels
    localparam int PAGE_W = 12;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int REF_W  = 8;
    localparam int FREE_W = 13;

    // Default sizing of the page store
    localparam int NUM_PAGES_DEF  = 4096;
    localparam int COUNT_BITS_DEF = 8;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INC   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEC   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_INIT  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd2;
    localparam logic [STAT_W-1:0] STAT_COUNT = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_INIT,
        CS_EXEC
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;      // capture request, launch memory reads
        logic init_start;  // clear stack depth and init walker
        logic init_step;   // process one page of the init walk
        logic commit;      // write back and load the response register
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic req_is_init; // request on the channel is an init
        logic init_last;   // init walker sits on the last page
        logic out_free;    // response register can take a new result
    } dp_status_t;

endpackage

// ===== rtl/rpalloc_if.sv =====
// ----------------------------------------------------------------------------
// rpalloc_if: request and response channels of the page allocator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface rpalloc_req_if;
    import rpalloc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PAGE_W-1:0] page;

    modport source (output valid, output func, output page, input ready);
    modport sink   (input valid, input func, input page, output ready);
endinterface

interface rpalloc_rsp_if;
    import rpalloc_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] result_page;
    logic [REF_W-1:0]  ref_count;
    logic [FREE_W-1:0] free_count;

    modport source (output valid, output status, output result_page,
                    output ref_count, output free_count, input ready);
    modport sink   (input valid, input status, input result_page,
                    input ref_count, input free_count, output ready);
endinterface

// ===== rtl/refcounted_page_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_allocator: page-frame allocator with reference counts
// Usage:
//   req carries func and page; a request is taken when valid and ready are
//   high. rsp returns one response per request: status, result_page,
//   ref_count and free_count. cfg_we/cfg_wdata write first_page; write it
//   only while no request is in flight.
// Sequence:
//   alloc, free, increment, decrement, query and unused codes run as a
//   capture step, which reads the count memory and the stack top, then an
//   execute step that writes back. The response register loads at the
//   write-back, so a new request is taken right after.
//   init walks the pages through the single write port of each memory, one
//   page per cycle.
// Reset:
//   depth and first_page clear to zero; memories are not cleared, so issue
//   init before any count is used.
// Stall:
//   if rsp is not taken, the next result waits in the execute step and
//   req.ready stays low until the response register frees.
// ----------------------------------------------------------------------------
module refcounted_page_allocator #(
    parameter int NUM_PAGES  = rpalloc_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = rpalloc_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpalloc_pkg::PAGE_W-1:0] cfg_wdata,
    rpalloc_req_if.sink                    req,
    rpalloc_rsp_if.source                  rsp
);
    import rpalloc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rpalloc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rpalloc_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_func   (req.func),
        .req_page   (req.page),
        .cmd        (cmd),
        .status     (status),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .rsp_status (rsp.status),
        .rsp_page   (rsp.result_page),
        .rsp_count  (rsp.ref_count),
        .rsp_free   (rsp.free_count)
    );

    // Write-back never overwrites a response that has not been taken
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while response register busy");

    // Write-back always presents a response next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("commit did not raise response valid");

    // Only one request in flight
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");

    // Failed alloc reports no page and no count
    a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STAT_NOMEM))
            |-> ((rsp.result_page == '0) && (rsp.ref_count == '0)))
        else $error("out-of-memory response carries a page");

endmodule

// ===== rtl/rpalloc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpalloc_ctrl: sequencing controller of the page allocator
// Accepts one request at a time, runs the init walk and issues the
// write-back once the response register is free.
// ----------------------------------------------------------------------------
module rpalloc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  rpalloc_pkg::dp_status_t status,
    output rpalloc_pkg::dp_cmd_t    cmd
);
    import rpalloc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        req_fire;

    assign req_fire = (state_reg == CS_IDLE) && req_valid;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = status.req_is_init ? CS_INIT : CS_EXEC;
                end
            end
            CS_INIT:
            begin
                if (status.init_last)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready      = (state_reg == CS_IDLE);
        cmd.accept     = req_fire;
        cmd.init_start = req_fire && status.req_is_init;
        cmd.init_step  = (state_reg == CS_INIT);
        cmd.commit     = (state_reg == CS_EXEC) && status.out_free;
    end

endmodule

// ===== rtl/rpalloc_dp.sv =====
// ----------------------------------------------------------------------------
// rpalloc_dp: datapath of the page allocator
// Holds the count memory, the free stack, the stack depth, the init walker
// and the response register; executes one operation per commit.
// ----------------------------------------------------------------------------
module rpalloc_dp #(
    parameter int NUM_PAGES  = rpalloc_pkg::NUM_PAGES_DEF,
    parameter int COUNT_BITS = rpalloc_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rpalloc_pkg::PAGE_W-1:0]   cfg_wdata,
    input  logic [rpalloc_pkg::FUNC_W-1:0]   req_func,
    input  logic [rpalloc_pkg::PAGE_W-1:0]   req_page,
    input  rpalloc_pkg::dp_cmd_t             cmd,
    output rpalloc_pkg::dp_status_t          status,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output logic [rpalloc_pkg::STAT_W-1:0]   rsp_status,
    output logic [rpalloc_pkg::PAGE_W-1:0]   rsp_page,
    output logic [rpalloc_pkg::REF_W-1:0]    rsp_count,
    output logic [rpalloc_pkg::FREE_W-1:0]   rsp_free
);
    import rpalloc_pkg::*;

    localparam int IDX_W   = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [DEPTH_W-1:0]    DEPTH_MAX = DEPTH_W'(NUM_PAGES);
    localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'(NUM_PAGES - 1);

    // Memories
    logic [COUNT_BITS-1:0] count_mem [NUM_PAGES];
    logic [IDX_W-1:0]      stack_mem [NUM_PAGES];

    // Registers
    logic [PAGE_W-1:0]     first_page_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [IDX_W-1:0]      stk_rd_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    logic [DEPTH_W-1:0]    depth_next;
    logic [IDX_W-1:0]      init_idx_reg;
    logic                  out_valid_reg;
    logic [STAT_W-1:0]     out_status_reg;
    logic [PAGE_W-1:0]     out_page_reg;
    logic [REF_W-1:0]      out_count_reg;
    logic [FREE_W-1:0]     out_free_reg;

    // Execute results
    logic                  in_range;
    logic                  below_first;
    logic [STAT_W-1:0]     e_status;
    logic [PAGE_W-1:0]     e_page;
    logic [COUNT_BITS-1:0] e_count;
    logic                  e_cnt_we;
    logic [IDX_W-1:0]      e_cnt_addr;
    logic                  e_push;
    logic                  e_pop;

    // Memory write port controls
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  stk_we;
    logic [IDX_W-1:0]      stk_waddr;
    logic [IDX_W-1:0]      stk_wdata;

    // Status back to the controller
    assign status.req_is_init = (req_func == FUNC_INIT);
    assign status.init_last   = (init_idx_reg == IDX_LAST);
    assign status.out_free    = !out_valid_reg || rsp_ready;

    assign in_range    = (page_reg >= first_page_reg) && (32'(page_reg) < 32'(NUM_PAGES));
    assign below_first = 32'(init_idx_reg) < 32'(first_page_reg);

    // Execute the captured request against the read data
    always_comb
    begin
        e_status   = STAT_OK;
        e_page     = '0;
        e_count    = '0;
        e_cnt_we   = 1'b0;
        e_cnt_addr = IDX_W'(page_reg);
        e_push     = 1'b0;
        e_pop      = 1'b0;
        unique case (func_reg)
            FUNC_ALLOC:
            begin
                if (depth_reg == '0)
                begin
                    e_status = STAT_NOMEM;
                end
                else
                begin
                    e_pop      = 1'b1;
                    e_cnt_we   = 1'b1;
                    e_cnt_addr = stk_rd_reg;
                    e_page     = PAGE_W'(stk_rd_reg);
                    e_count    = COUNT_ONE;
                end
            end
            FUNC_FREE:
            begin
                if (!in_range)
                begin
                    e_status = STAT_RANGE;
                end
                else if (cnt_rd_reg > COUNT_ONE)
                begin
                    e_cnt_we = 1'b1;
                    e_page   = page_reg;
                    e_count  = cnt_rd_reg - COUNT_ONE;
                end
                else if ((cnt_rd_reg == COUNT_ONE) && (depth_reg < DEPTH_MAX))
                begin
                    e_cnt_we = 1'b1;
                    e_push   = 1'b1;
                    e_page   = page_reg;
                end
                else
                begin
                    e_status = STAT_COUNT;
                end
            end
            FUNC_INC:
            begin
                if (!in_range)
                begin
                    e_status = STAT_RANGE;
                end
                else if (cnt_rd_reg == COUNT_MAX)
                begin
                    e_status = STAT_COUNT;
                end
                else
                begin
                    e_cnt_we = 1'b1;
                    e_page   = page_reg;
                    e_count  = cnt_rd_reg + COUNT_ONE;
                end
            end
            FUNC_DEC:
            begin
                if (!in_range)
                begin
                    e_status = STAT_RANGE;
                end
                else if (cnt_rd_reg == '0)
                begin
                    e_status = STAT_COUNT;
                end
                else
                begin
                    e_cnt_we = 1'b1;
                    e_page   = page_reg;
                    e_count  = cnt_rd_reg - COUNT_ONE;
                end
            end
            FUNC_QUERY:
            begin
                if (!in_range)
                begin
                    e_status = STAT_RANGE;
                end
                else
                begin
                    e_page  = page_reg;
                    e_count = cnt_rd_reg;
                end
            end
            default:
            begin
                // init result and unused codes report ok with no change
                e_status = STAT_OK;
            end
        endcase
    end

    // Select the memory write ports: init walk or write-back
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = e_cnt_addr;
        cnt_wdata = e_count;
        stk_we    = 1'b0;
        stk_waddr = IDX_W'(depth_reg);
        stk_wdata = IDX_W'(page_reg);
        if (cmd.init_step)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = init_idx_reg;
            cnt_wdata = below_first ? COUNT_ONE : '0;
            stk_we    = !below_first;
            stk_wdata = init_idx_reg;
        end
        else if (cmd.commit)
        begin
            cnt_we = e_cnt_we;
            stk_we = e_push;
        end
    end

    // Count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.accept)
        begin
            cnt_rd_reg <= count_mem[IDX_W'(req_page)];
        end
    end

    // Free stack memory; the top entry is read on accept
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (cmd.accept)
        begin
            stk_rd_reg <= stack_mem[IDX_W'(depth_reg - 1'b1)];
        end
    end

    // Stack depth after this cycle
    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.init_start)
        begin
            depth_next = '0;
        end
        else if (cmd.init_step)
        begin
            if (!below_first)
            begin
                depth_next = depth_reg + 1'b1;
            end
        end
        else if (cmd.commit)
        begin
            if (e_pop)
            begin
                depth_next = depth_reg - 1'b1;
            end
            else if (e_push)
            begin
                depth_next = depth_reg + 1'b1;
            end
        end
    end

    // Control registers: config, depth, init walker, response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= '0;
            depth_reg      <= '0;
            init_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                first_page_reg <= cfg_wdata;
            end
            depth_reg <= depth_next;
            if (cmd.init_start)
            begin
                init_idx_reg <= '0;
            end
            else if (cmd.init_step)
            begin
                init_idx_reg <= init_idx_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: captured request and response
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= req_func;
            page_reg <= req_page;
        end
        if (cmd.commit)
        begin
            out_status_reg <= e_status;
            out_page_reg   <= e_page;
            out_count_reg  <= REF_W'(e_count);
            out_free_reg   <= FREE_W'(depth_next);
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_page   = out_page_reg;
    assign rsp_count  = out_count_reg;
    assign rsp_free   = out_free_reg;

endmodule

// ===== dv/tb_refcounted_page_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_refcounted_page_allocator: self-checking bench for the page allocator
// Drives requests through a queue-fed driver and checks every response
// against a predictor of the free stack and reference counts. The run covers
// directed corner cases and then random sequences under varied idling and
// back-pressure, with several first_page settings.
// ----------------------------------------------------------------------------
module tb_refcounted_page_allocator;
    import rpalloc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;
    localparam int                PAGES       = NUM_PAGES_DEF;
    localparam int                COUNT_TOP   = (1 << COUNT_BITS_DEF) - 1;

    // One request as queued for the driver; hold marks a drain point
    typedef struct packed {
        logic              hold;
        logic [FUNC_W-1:0] func;
        logic [PAGE_W-1:0] page;
    } page_req_t;

    // One response as predicted or observed
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PAGE_W-1:0] page;
        logic [REF_W-1:0]  count;
        logic [FREE_W-1:0] free_cnt;
    } page_rsp_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [PAGE_W-1:0]   cfg_wdata;

    rpalloc_req_if req ();
    rpalloc_rsp_if rsp ();

    // Shadow of the allocator state
    logic [REF_W-1:0]    ref_tab [PAGES];
    logic [PAGE_W-1:0]   free_stk [PAGES];
    int                  stack_top;
    logic [PAGE_W-1:0]   first_pg;

    page_req_t           pending_reqs[$];
    page_rsp_t           expected_rsps[$];
    bit                  req_taken;
    int                  src_idle_pct;
    int                  snk_idle_pct;
    bit                  long_hold_req;
    int                  hold_left;
    int                  fail_count;

    refcounted_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one request to the shadow state and return its response
    function automatic page_rsp_t apply_page_req(input logic [FUNC_W-1:0] f,
                                                 input logic [PAGE_W-1:0] pg);
        page_rsp_t r;
        int        c;
        int        i;
        bit        legal;
        r = '0;
        r.status = STAT_OK;
        case (f)
            FUNC_ALLOC:
            begin
                if (stack_top == 0)
                begin
                    r.status = STAT_NOMEM;
                end
                else
                begin
                    stack_top--;
                    i = free_stk[stack_top];
                    ref_tab[i] = 1;
                    r.page = i[PAGE_W-1:0];
                    r.count = 1;
                end
            end
            FUNC_INIT:
            begin
                stack_top = 0;
                for (i = 0; i < PAGES; i++)
                begin
                    if (i < first_pg)
                    begin
                        ref_tab[i] = 1;
                    end
                    else
                    begin
                        ref_tab[i] = 0;
                        free_stk[stack_top] = i[PAGE_W-1:0];
                        stack_top++;
                    end
                end
            end
            FUNC_FREE, FUNC_INC, FUNC_DEC, FUNC_QUERY:
            begin
                if (pg < first_pg)
                begin
                    r.status = STAT_RANGE;
                end
                else
                begin
                    c = ref_tab[pg];
                    legal = 1'b1;
                    if (f == FUNC_FREE)
                    begin
                        if (c > 1)
                        begin
                            c--;
                        end
                        else if (c == 1 && stack_top < PAGES)
                        begin
                            free_stk[stack_top] = pg;
                            stack_top++;
                            c = 0;
                        end
                        else
                        begin
                            legal = 1'b0;
                        end
                    end
                    else if (f == FUNC_INC)
                    begin
                        if (c >= COUNT_TOP)
                            legal = 1'b0;
                        else
                            c++;
                    end
                    else if (f == FUNC_DEC)
                    begin
                        if (c == 0)
                            legal = 1'b0;
                        else
                            c--;
                    end
                    if (legal)
                    begin
                        ref_tab[pg] = c[REF_W-1:0];
                        r.page = pg;
                        r.count = c[REF_W-1:0];
                    end
                    else
                    begin
                        r.status = STAT_COUNT;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.free_cnt = stack_top[FREE_W-1:0];
        return r;
    endfunction

    // Driver: offer queued requests at the falling edge
    always @(negedge clk)
    begin
        page_req_t         nxt;
        logic              drv_valid;
        logic [FUNC_W-1:0] drv_func;
        logic [PAGE_W-1:0] drv_page;
        drv_valid = req.valid;
        drv_func = req.func;
        drv_page = req.page;
        if (req_taken)
        begin
            drv_valid = 1'b0;
            req_taken = 1'b0;
        end
        if (rst_n && !drv_valid && pending_reqs.size() > 0)
        begin
            if (pending_reqs[0].hold)
            begin
                // hold off until every response is back
                if (expected_rsps.size() == 0)
                    nxt = pending_reqs.pop_front();
            end
            else if ($urandom_range(99) >= src_idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                drv_valid = 1'b1;
                drv_func = nxt.func;
                drv_page = nxt.page;
            end
        end
        req.valid <= drv_valid;
        req.func <= drv_func;
        req.page <= drv_page;
    end

    // Receiver: random stalls plus an occasional long hold
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            hold_left = 150;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Monitor: track config, predict accepted requests, check responses
    always @(posedge clk)
    begin
        page_rsp_t want;
        if (rst_n)
        begin
            if (cfg_we)
                first_pg = cfg_wdata;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response with no request pending: status %0d page %0d",
                           rsp.status, rsp.result_page);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.result_page !== want.page)
                    begin
                        $error("result_page: expected %0d, got %0d",
                               want.page, rsp.result_page);
                        fail_count++;
                    end
                    if (rsp.ref_count !== want.count)
                    begin
                        $error("ref_count: expected %0d, got %0d", want.count, rsp.ref_count);
                        fail_count++;
                    end
                    if (rsp.free_count !== want.free_cnt)
                    begin
                        $error("free_count: expected %0d, got %0d",
                               want.free_cnt, rsp.free_count);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_rsps.push_back(apply_page_req(req.func, req.page));
                req_taken = 1'b1;
            end
        end
    end

    task automatic add_req(input logic [FUNC_W-1:0] f, input logic [PAGE_W-1:0] pg);
        page_req_t q;
        q.hold = 1'b0;
        q.func = f;
        q.page = pg;
        pending_reqs.push_back(q);
    endtask

    task automatic add_drain();
        page_req_t q;
        q = '0;
        q.hold = 1'b1;
        pending_reqs.push_back(q);
    endtask

    // Wait until the block is idle with nothing outstanding
    task automatic settle();
        while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_first_page(input logic [PAGE_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random requests aimed mostly at the pages that allocs hand out
    task automatic add_random_reqs(input int n, input int fp);
        int                win_lo;
        int                near_hi;
        int                k;
        int                r;
        logic [FUNC_W-1:0] f;
        logic [PAGE_W-1:0] pg;
        win_lo = (fp > PAGES - 48) ? fp : PAGES - 48;
        near_hi = (fp + 15 > PAGES - 1) ? PAGES - 1 : fp + 15;
        for (k = 0; k < n; k++)
        begin
            if (k == n / 2)
                add_drain();
            r = $urandom_range(99);
            if (r < 28)
                f = FUNC_ALLOC;
            else if (r < 52)
                f = FUNC_FREE;
            else if (r < 66)
                f = FUNC_INC;
            else if (r < 80)
                f = FUNC_DEC;
            else if (r < 92)
                f = FUNC_QUERY;
            else if (r < 95)
                f = FUNC_SPARE6;
            else if (r < 99)
                f = FUNC_SPARE7;
            else
                f = FUNC_INIT;
            r = $urandom_range(99);
            if (r < 65)
                pg = PAGE_W'($urandom_range(win_lo, PAGES - 1));
            else if (r < 75 && fp > 0)
                pg = PAGE_W'($urandom_range(0, fp - 1));
            else if (r < 85)
                pg = PAGE_W'($urandom_range(fp, near_hi));
            else
                pg = PAGE_W'($urandom);
            add_req(f, pg);
        end
    endtask

    // Stimulus
    initial
    begin
        int k;
        int fp;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.func = FUNC_QUERY;
        req.page = '0;
        rsp.ready = 1'b0;
        req_taken = 1'b0;
        long_hold_req = 1'b0;
        hold_left = 0;
        fail_count = 0;
        stack_top = 0;
        first_pg = '0;
        for (k = 0; k < PAGES; k++)
        begin
            ref_tab[k] = '0;
            free_stk[k] = '0;
        end
        src_idle_pct = 28;
        snk_idle_pct = 76;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // One managed page: range errors, empty stack, double free, underflow
        write_first_page(12'hFFF);
        add_req(FUNC_INIT, 12'h000);
        add_req(FUNC_QUERY, 12'h000);
        add_req(FUNC_QUERY, 12'hFFE);
        add_req(FUNC_QUERY, 12'hFFF);
        add_req(FUNC_ALLOC, 12'h000);
        add_req(FUNC_ALLOC, 12'hFFF);
        add_req(FUNC_INC, 12'hFFF);
        add_req(FUNC_DEC, 12'hFFF);
        add_req(FUNC_FREE, 12'hFFF);
        add_req(FUNC_FREE, 12'hFFF);
        add_req(FUNC_DEC, 12'hFFF);
        add_req(FUNC_INC, 12'hFFF);
        add_req(FUNC_SPARE6, 12'hAAA);
        add_req(FUNC_SPARE7, 12'h555);
        settle();

        // All pages managed: free onto a full stack, decrement to zero
        write_first_page(12'h000);
        add_req(FUNC_INIT, 12'hFFF);
        add_req(FUNC_QUERY, 12'h000);
        add_req(FUNC_INC, 12'h007);
        add_req(FUNC_FREE, 12'h007);
        add_req(FUNC_DEC, 12'h007);
        add_req(FUNC_ALLOC, 12'h000);
        add_req(FUNC_FREE, 12'hFFF);
        settle();

        // Random sequences, sender lightly idle, receiver mostly stalled
        write_first_page(12'd100);
        add_req(FUNC_INIT, 12'h000);
        add_random_reqs(160, 100);
        settle();

        write_first_page(12'd4080);
        add_req(FUNC_INIT, 12'h000);
        add_random_reqs(150, 4080);
        settle();

        // Idling swapped; pump one page up to count overflow
        src_idle_pct = 76;
        snk_idle_pct = 28;
        write_first_page(12'hFFF);
        add_req(FUNC_INIT, 12'h000);
        add_req(FUNC_ALLOC, 12'h000);
        for (k = 0; k < COUNT_TOP; k++)
            add_req(FUNC_INC, 12'hFFF);
        add_random_reqs(40, 4095);
        settle();

        fp = $urandom_range(1, 3000);
        write_first_page(fp[PAGE_W-1:0]);
        add_req(FUNC_INIT, 12'h000);
        add_random_reqs(150, fp);
        settle();

        // No idling; long receiver hold fills the block and stalls requests
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_first_page(12'h000);
        add_req(FUNC_INIT, 12'h000);
        add_random_reqs(140, 0);
        long_hold_req = 1'b1;
        settle();

        // Move first_page over live tables without a fresh init
        fp = $urandom_range(0, PAGES - 1);
        write_first_page(fp[PAGE_W-1:0]);
        add_random_reqs(130, fp);
        settle();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS refcounted_page_allocator");
        else
            $display("FAIL refcounted_page_allocator");
        $finish;
    end

    // Run limit
    initial
    begin
        #20000000;
        $display("FAIL refcounted_page_allocator");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rpalloc_pkg.sv
rtl/rpalloc_if.sv
rtl/rpalloc_ctrl.sv
rtl/rpalloc_dp.sv
rtl/refcounted_page_allocator.sv
dv/tb_refcounted_page_allocator.sv
